FILE: sv/sdspi_pkg.sv
// shared types, phase codes and command frame constants for the sd spi init sequencer
// no dependencies
package sdspi_pkg;

  localparam logic [4:0] PH_IDLE       = 5'd0;
  localparam logic [4:0] PH_WAKE       = 5'd1;
  localparam logic [4:0] PH_CMD0_TX    = 5'd2;
  localparam logic [4:0] PH_CMD0_RX    = 5'd3;
  localparam logic [4:0] PH_CMD8_TX    = 5'd4;
  localparam logic [4:0] PH_CMD8_RX    = 5'd5;
  localparam logic [4:0] PH_CMD8_TAIL  = 5'd6;
  localparam logic [4:0] PH_CMD55_TX   = 5'd7;
  localparam logic [4:0] PH_CMD55_RX   = 5'd8;
  localparam logic [4:0] PH_ACMD41_TX  = 5'd9;
  localparam logic [4:0] PH_ACMD41_RX  = 5'd10;
  localparam logic [4:0] PH_CMD58_TX   = 5'd11;
  localparam logic [4:0] PH_CMD58_RX   = 5'd12;
  localparam logic [4:0] PH_CMD58_OCR  = 5'd13;
  localparam logic [4:0] PH_CMD58_TAIL = 5'd14;
  localparam logic [4:0] PH_DONE       = 5'd15;
  localparam logic [4:0] PH_FAIL_IDLE  = 5'd16;
  localparam logic [4:0] PH_FAIL_ECHO  = 5'd17;
  localparam logic [4:0] PH_FAIL_OCR   = 5'd18;

  localparam logic CMD_START    = 1'b0;
  localparam logic CMD_EXCHANGE = 1'b1;

  localparam logic REG_WAKE_COUNT = 1'b0;
  localparam logic REG_POLL_LIMIT = 1'b1;

  localparam logic [7:0] FRAME_START = 8'h40;
  localparam logic [7:0] CODE_CMD8   = 8'h08;
  localparam logic [7:0] CODE_CMD55  = 8'h37;
  localparam logic [7:0] CODE_ACMD41 = 8'h29;
  localparam logic [7:0] CODE_CMD58  = 8'h3a;
  localparam logic [7:0] CRC_CMD0    = 8'h95;
  localparam logic [7:0] CRC_CMD8    = 8'h87;
  localparam logic [7:0] IDLE_BYTE   = 8'hff;
  localparam logic [7:0] R1_IDLE     = 8'h01;
  localparam logic [7:0] CHECK_ECHO  = 8'haa;
  localparam logic [7:0] CMD8_ARG_LO = 8'haa;
  localparam logic [7:0] CMD8_ARG_MID = 8'h01;
  localparam logic [7:0] HCS_ARG_HI  = 8'h40;
  localparam logic [7:0] OCR_CAP_MASK = 8'hc0;
  localparam logic [7:0] FRAME_LAST  = 8'd5;
  localparam logic [7:0] ECHO_LEN    = 8'd4;
  localparam logic [7:0] OCR_TAIL_LEN = 8'd3;

  localparam logic [7:0] WAKE_RESET  = 8'd10;
  localparam logic [8:0] POLL_RESET  = 9'd256;

  typedef struct packed {
    logic [4:0] phase;
    logic [7:0] byte_cnt;
    logic [8:0] poll_cnt;
    logic       is_v2;
    logic       is_hc;
  } seq_state_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_request;
    logic       select_asserted;
    logic       done_res;
    logic [1:0] outcome;
    logic       card_v2;
    logic       high_capacity;
  } seq_result_t;

  // byte idx of the 6-byte command frame for the command phase ph
  function automatic logic [7:0] frame_byte(input logic [4:0] ph, input logic [7:0] idx,
                                            input logic v2);
    logic [7:0] code;
    logic [7:0] res;
    begin
      code = 8'h00;
      res  = 8'h00;
      unique case (ph)
        PH_CMD8_TX:   code = CODE_CMD8;
        PH_CMD55_TX:  code = CODE_CMD55;
        PH_ACMD41_TX: code = CODE_ACMD41;
        PH_CMD58_TX:  code = CODE_CMD58;
        default:      code = 8'h00;
      endcase
      if (idx == 8'd0) begin
        res = FRAME_START | code;
      end else if (idx < FRAME_LAST) begin
        // argument bytes, msb first
        if (ph == PH_CMD8_TX && idx == 8'd3) begin
          res = CMD8_ARG_MID;
        end else if (ph == PH_CMD8_TX && idx == 8'd4) begin
          res = CMD8_ARG_LO;
        end else if (ph == PH_ACMD41_TX && v2 && idx == 8'd1) begin
          res = HCS_ARG_HI;
        end
      end else if (ph == PH_CMD0_TX) begin
        res = CRC_CMD0;
      end else if (ph == PH_CMD8_TX) begin
        res = CRC_CMD8;
      end else begin
        res = IDLE_BYTE;
      end
      return res;
    end
  endfunction

endpackage

FILE: sv/sdspi_next.sv
// next-state and result logic of the sd spi init sequencer for one transaction
// depends on sdspi_pkg
module sdspi_next import sdspi_pkg::*; (
  input  seq_state_t  state_i,
  input  logic        cmd_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  wake_count_i,
  input  logic [8:0]  poll_limit_i,
  output seq_state_t  state_o,
  output seq_result_t result_o
);

  seq_state_t st;
  logic [7:0] tx;
  logic       req;
  logic       done;

  always_comb begin
    st  = state_i;
    tx  = IDLE_BYTE;
    req = 1'b0;
    if (cmd_i == CMD_START) begin
      st.byte_cnt = 8'd0;
      st.poll_cnt = 9'd0;
      st.is_v2    = 1'b0;
      st.is_hc    = 1'b0;
      req         = 1'b1;
      if (wake_count_i == 8'd0) begin
        st.phase = PH_CMD0_TX;
        tx       = frame_byte(PH_CMD0_TX, 8'd0, 1'b0);
      end else begin
        st.phase    = PH_WAKE;
        st.byte_cnt = 8'd1;
      end
    end else begin
      unique case (state_i.phase)
        PH_WAKE: begin
          req = 1'b1;
          if (state_i.byte_cnt < wake_count_i) begin
            st.byte_cnt = state_i.byte_cnt + 8'd1;
          end else begin
            st.phase    = PH_CMD0_TX;
            st.byte_cnt = 8'd0;
            tx          = frame_byte(PH_CMD0_TX, 8'd0, state_i.is_v2);
          end
        end
        PH_CMD0_TX, PH_CMD8_TX, PH_CMD55_TX, PH_ACMD41_TX, PH_CMD58_TX: begin
          req = 1'b1;
          if (state_i.byte_cnt < FRAME_LAST) begin
            st.byte_cnt = state_i.byte_cnt + 8'd1;
            tx = frame_byte(state_i.phase, state_i.byte_cnt + 8'd1, state_i.is_v2);
          end else begin
            st.phase    = state_i.phase + 5'd1;
            st.poll_cnt = 9'd0;
          end
        end
        PH_CMD0_RX, PH_CMD8_RX, PH_CMD55_RX, PH_ACMD41_RX, PH_CMD58_RX: begin
          if (rx_byte_i[7] && state_i.poll_cnt < poll_limit_i) begin
            // keep polling for r1
            st.poll_cnt = state_i.poll_cnt + 9'd1;
            req         = 1'b1;
          end else begin
            unique case (state_i.phase)
              PH_CMD0_RX: begin
                if (rx_byte_i != R1_IDLE) begin
                  st.phase = PH_FAIL_IDLE;
                end else begin
                  req         = 1'b1;
                  st.phase    = PH_CMD8_TX;
                  st.byte_cnt = 8'd0;
                  tx          = frame_byte(PH_CMD8_TX, 8'd0, state_i.is_v2);
                end
              end
              PH_CMD8_RX: begin
                req = 1'b1;
                if (rx_byte_i[2]) begin
                  // illegal command, version 1 card
                  st.is_v2    = 1'b0;
                  st.phase    = PH_CMD55_TX;
                  st.byte_cnt = 8'd0;
                  tx          = frame_byte(PH_CMD55_TX, 8'd0, 1'b0);
                end else begin
                  st.phase    = PH_CMD8_TAIL;
                  st.byte_cnt = 8'd0;
                end
              end
              PH_CMD55_RX: begin
                req         = 1'b1;
                st.phase    = PH_ACMD41_TX;
                st.byte_cnt = 8'd0;
                tx          = frame_byte(PH_ACMD41_TX, 8'd0, state_i.is_v2);
              end
              PH_ACMD41_RX: begin
                if (rx_byte_i != 8'h00) begin
                  req         = 1'b1;
                  st.phase    = PH_CMD55_TX;
                  st.byte_cnt = 8'd0;
                  tx          = frame_byte(PH_CMD55_TX, 8'd0, state_i.is_v2);
                end else if (state_i.is_v2) begin
                  req         = 1'b1;
                  st.phase    = PH_CMD58_TX;
                  st.byte_cnt = 8'd0;
                  tx          = frame_byte(PH_CMD58_TX, 8'd0, state_i.is_v2);
                end else begin
                  st.phase = PH_DONE;
                end
              end
              default: begin
                if (rx_byte_i != 8'h00) begin
                  st.phase = PH_FAIL_OCR;
                end else begin
                  req      = 1'b1;
                  st.phase = PH_CMD58_OCR;
                end
              end
            endcase
          end
        end
        PH_CMD8_TAIL: begin
          st.byte_cnt = state_i.byte_cnt + 8'd1;
          req         = 1'b1;
          if (state_i.byte_cnt + 8'd1 >= ECHO_LEN) begin
            if (rx_byte_i != CHECK_ECHO) begin
              st.phase = PH_FAIL_ECHO;
              req      = 1'b0;
            end else begin
              st.is_v2    = 1'b1;
              st.phase    = PH_CMD55_TX;
              st.byte_cnt = 8'd0;
              tx          = frame_byte(PH_CMD55_TX, 8'd0, 1'b1);
            end
          end
        end
        PH_CMD58_OCR: begin
          if ((rx_byte_i & OCR_CAP_MASK) == OCR_CAP_MASK) begin
            st.is_hc = 1'b1;
          end
          st.phase    = PH_CMD58_TAIL;
          st.byte_cnt = 8'd0;
          req         = 1'b1;
        end
        PH_CMD58_TAIL: begin
          st.byte_cnt = state_i.byte_cnt + 8'd1;
          if (state_i.byte_cnt + 8'd1 < OCR_TAIL_LEN) begin
            req = 1'b1;
          end else begin
            st.phase = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign done    = (st.phase >= PH_DONE);
  assign state_o = st;

  always_comb begin
    result_o.tx_byte         = req ? tx : IDLE_BYTE;
    result_o.tx_request      = req;
    result_o.select_asserted = (st.phase >= PH_CMD0_TX) && (st.phase < PH_DONE);
    result_o.done_res        = done;
    result_o.outcome         = done ? 2'(st.phase - PH_DONE) : 2'd0;
    result_o.card_v2         = st.is_v2;
    result_o.high_capacity   = st.is_hc;
  end

endmodule

FILE: sv/sd_card_spi_init_sequencer.sv
// top level of the sd card spi-mode init sequencer: config registers, state, result register
// depends on sdspi_pkg and sdspi_next
//
// One input transaction is either a start (cmd 0) or the report of a finished
// spi byte exchange (cmd 1) carrying the byte received from the card. Every
// accepted transaction yields exactly one result transaction: the next byte to
// shift out, whether another exchange is wanted, the chip-select level, and,
// once the sequence ends, the outcome (0 ready, 1 no idle after cmd0, 2 cmd8
// echo wrong, 3 cmd58 failed) with the card version and capacity flags. The
// block takes one transaction per clock: the sequencer state and the result
// register are both updated at the accepting edge, so the only limit is the
// single result register, which refills in the same cycle it is drained.
// Configuration (wake byte count, response poll limit) is written through its
// own valid/ready channel and is always ready; write it only while idle.
module sd_card_spi_init_sequencer import sdspi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [8:0] cfg_data_i,
  // input transactions
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_i,
  input  logic [7:0] rx_byte_i,
  // result transactions
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] tx_byte_o,
  output logic       tx_request_o,
  output logic       select_asserted_o,
  output logic       done_res_o,
  output logic [1:0] outcome_o,
  output logic       card_v2_o,
  output logic       high_capacity_o
);

  logic [7:0]  wake_count_q;
  logic [8:0]  poll_limit_q;
  seq_state_t  state_q, state_d;
  seq_result_t result_q, result_d;
  logic        out_valid_q;
  logic        in_fire;

  // accept whenever the result register is empty or being drained this cycle
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wake_count_q <= WAKE_RESET;
      poll_limit_q <= POLL_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WAKE_COUNT: wake_count_q <= cfg_data_i[7:0];
        REG_POLL_LIMIT: poll_limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  sdspi_next u_next (
    .state_i      (state_q),
    .cmd_i        (cmd_i),
    .rx_byte_i    (rx_byte_i),
    .wake_count_i (wake_count_q),
    .poll_limit_i (poll_limit_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  // sequencer state advances only on an accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign tx_byte_o         = result_q.tx_byte;
  assign tx_request_o      = result_q.tx_request;
  assign select_asserted_o = result_q.select_asserted;
  assign done_res_o        = result_q.done_res;
  assign outcome_o         = result_q.outcome;
  assign card_v2_o         = result_q.card_v2;
  assign high_capacity_o   = result_q.high_capacity;

endmodule
